@@ hdl/puct_pkg.sv @@
// ----------------------------------------------------------------------------
// PUCT child selector package
// Shared widths, constants, codes and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package puct_pkg;

  // Fixed-point format and list limits.
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned MAX_CHILDREN = 1024;
  localparam int unsigned IDX_W        = $clog2(MAX_CHILDREN);
  localparam int unsigned CNT_W        = IDX_W + 1;

  // Scores are signed 40 bits; a computed score never exceeds 2^39 - 1.
  localparam int unsigned SCORE_W = 40;
  localparam logic [SCORE_W-2:0] SCORE_MAX = '1;
  localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  localparam logic [31:0] ONE_Q   = 32'(1) << FRAC_BITS;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // Serial unit widths.
  localparam int unsigned LOG_IN_W    = 49;
  localparam int unsigned LOG_K_W     = 6;
  localparam int unsigned LOG_W       = LOG_K_W + FRAC_BITS;
  localparam int unsigned DIV_N_W     = 48;
  localparam int unsigned DIV_D_W     = 33;
  localparam int unsigned SQRT_IN_W   = 66;
  localparam int unsigned SQRT_ROOT_W = SQRT_IN_W / 2;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_EXPLORE_BASE      = 3'd0,
    CFG_EXPLORE_INIT      = 3'd1,
    CFG_EXPLORE_BASE_ROOT = 3'd2,
    CFG_EXPLORE_INIT_ROOT = 3'd3,
    CFG_FPU_SCALE         = 3'd4,
    CFG_FPU_SCALE_ROOT    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUTCOME_UNKNOWN = 2'd0,
    OUTCOME_WIN     = 2'd1,
    OUTCOME_LOSS    = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    VERDICT_NONE        = 2'd0,
    VERDICT_PARENT_WIN  = 2'd1,
    VERDICT_PARENT_LOSS = 2'd2
  } verdict_e;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FRAME,
    OP_SCAN,
    OP_START_A,
    OP_CAPTURE_A,
    OP_START_B,
    OP_CAPTURE_B,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_MUL4,
    OP_MUL5,
    OP_MUL6,
    OP_UPDATE,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAME,
    ST_SCAN,
    ST_START_A,
    ST_WAIT_A,
    ST_START_B,
    ST_WAIT_B,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_MUL5,
    ST_MUL6,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic child_won;
    logic last;
    logic units_done;
  } dp_status_t;

  // Clamp an unsigned value to the largest score.
  function automatic logic [SCORE_W-2:0] sat_score(input logic [65:0] v);
    return (v > 66'(SCORE_MAX)) ? SCORE_MAX : v[SCORE_W-2:0];
  endfunction

endpackage

@@ hdl/puct_div.sv @@
// ----------------------------------------------------------------------------
// PUCT serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module puct_div import puct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  logic [DIV_D_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quotient_o
);

  localparam int unsigned CNT_BITS = $clog2(DIV_N_W + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DIV_N_W-1:0] quo_q, quo_d;
  logic [DIV_D_W-1:0] rem_q, rem_d;
  logic [DIV_D_W-1:0] dsr_q, dsr_d;
  logic [DIV_D_W:0]   shifted;
  logic               ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, quo_q[DIV_N_W-1]};
    ge      = (shifted >= {1'b0, dsr_q});
    busy_d  = busy_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CNT_BITS'(DIV_N_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DIV_D_W'(shifted - {1'b0, dsr_q}) : shifted[DIV_D_W-1:0];
      quo_d = {quo_q[DIV_N_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ hdl/puct_sqrt.sv @@
// ----------------------------------------------------------------------------
// PUCT serial square root
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module puct_sqrt import puct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SQRT_IN_W-1:0]   radicand_i,
  output logic                   done_o,
  output logic [SQRT_ROOT_W-1:0] root_o
);

  localparam int unsigned REM_W    = SQRT_ROOT_W + 3;
  localparam int unsigned CNT_BITS = $clog2(SQRT_ROOT_W + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic [SQRT_IN_W-1:0]   rad_q, rad_d;
  logic [SQRT_ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [REM_W-1:0]       rem_sh;
  logic [REM_W-1:0]       trial;

  // Bring down two radicand bits and test the next root bit.
  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[SQRT_IN_W-1 -: 2]};
    trial  = (REM_W'(root_q) << 2) | REM_W'(1);
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CNT_BITS'(SQRT_ROOT_W);
      rad_d  = radicand_i;
      root_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[SQRT_ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[SQRT_ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hdl/puct_log.sv @@
// ----------------------------------------------------------------------------
// PUCT serial log2
// Base-2 logarithm of a positive integer: a normalizing shift phase finds the
// integer part, then repeated squaring yields one fraction bit per cycle.
// ----------------------------------------------------------------------------
module puct_log import puct_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [LOG_IN_W-1:0] x_i,
  output logic                done_o,
  output logic [LOG_W-1:0]    log_o
);

  localparam int unsigned M_W      = 31;
  localparam int unsigned CNT_BITS = $clog2(FRAC_BITS + 1);

  logic                busy_q, busy_d;
  logic                sq_q, sq_d;
  logic                done_q, done_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [LOG_IN_W-1:0] x_q, x_d;
  logic [LOG_K_W-1:0]  k_q, k_d;
  logic [M_W-1:0]      m_q, m_d;
  logic [FRAC_BITS-1:0] frac_q, frac_d;
  logic [2*M_W-1:0]    prod;
  logic [M_W:0]        sq;

  assign prod = m_q * m_q;
  assign sq   = prod[2*M_W-1 -: (M_W + 1)];

  always_comb begin
    busy_d = busy_q;
    sq_d   = sq_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    k_d    = k_q;
    m_d    = m_q;
    frac_d = frac_q;
    if (start_i) begin
      busy_d = 1'b1;
      sq_d   = 1'b0;
      done_d = 1'b0;
      x_d    = (x_i == '0) ? LOG_IN_W'(1) : x_i;
      k_d    = LOG_K_W'(LOG_IN_W - 1);
      frac_d = '0;
    end else if (busy_q && !sq_q) begin
      // Normalize: left-align the leading one, eight places at a time if possible.
      if (x_q[LOG_IN_W-1]) begin
        sq_d  = 1'b1;
        m_d   = x_q[LOG_IN_W-1 -: M_W];
        cnt_d = CNT_BITS'(FRAC_BITS);
      end else if (x_q[LOG_IN_W-1 -: 8] == '0 && k_q >= LOG_K_W'(8)) begin
        x_d = x_q << 8;
        k_d = k_q - LOG_K_W'(8);
      end else begin
        x_d = x_q << 1;
        k_d = k_q - LOG_K_W'(1);
      end
    end else if (busy_q) begin
      // Square the mantissa; an overflow past two gives a one fraction bit.
      if (sq[M_W]) begin
        m_d    = sq[M_W:1];
        frac_d = {frac_q[FRAC_BITS-2:0], 1'b1};
      end else begin
        m_d    = sq[M_W-1:0];
        frac_d = {frac_q[FRAC_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sq_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      sq_q   <= sq_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    k_q    <= k_d;
    m_q    <= m_d;
    frac_q <= frac_d;
  end

  assign done_o = done_q;
  assign log_o  = {k_q, frac_q};

endmodule

@@ hdl/puct_dp.sv @@
// ----------------------------------------------------------------------------
// PUCT datapath
// Holds the configuration, the current child, the serial math units, the
// scoring pipeline registers, the running argmax and the result register.
// ----------------------------------------------------------------------------
module puct_dp import puct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic [31:0]      parent_visits_i,
  input  logic [47:0]      parent_win_sum_i,
  input  logic [26:0]      parent_prior_sum_i,
  input  logic             at_root_i,
  input  logic [47:0]      child_win_i,
  input  logic [31:0]      child_visits_i,
  input  logic [16:0]      child_prior_i,
  input  logic             child_expanded_i,
  input  logic [1:0]       child_outcome_i,
  input  logic             first_child_i,
  input  logic             last_child_i,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  output logic [IDX_W-1:0] best_index_o,
  output logic [1:0]       parent_verdict_o,
  output logic             add_prior_o,
  output logic [16:0]      best_prior_o
);

  localparam int unsigned S_W = SCORE_W - 1;

  // Configuration registers.
  logic [31:0] base_q, init_q, base_root_q, init_root_q;
  logic [19:0] fs_q, fs_root_q;

  // Current child.
  logic [31:0] it_n_q;
  logic [47:0] it_w_q;
  logic [26:0] it_ps_q;
  logic        it_root_q;
  logic [47:0] it_cw_q;
  logic [31:0] it_cv_q;
  logic [16:0] it_prior_q;
  logic        it_exp_q;
  logic [1:0]  it_outcome_q;
  logic        it_first_q;
  logic        it_last_q;

  // List state.
  logic [SCORE_W-1:0] best_score_q;
  logic [IDX_W-1:0]   best_slot_q;
  logic               best_exp_q;
  logic [16:0]        best_prior_q;
  logic [CNT_W-1:0]   won_q;
  logic               lost_q;
  logic [CNT_W-1:0]   cnt_q;

  // Scoring pipeline.
  logic [LOG_W-1:0]   la_q, lb_q;
  logic [31:0]        ss_q;
  logic [21:0]        sp_q;
  logic [DIV_N_W-1:0] quot1_q;
  logic [31:0]        quot2_q;
  logic [51:0]        dl_prod_q;
  logic [41:0]        fpu_prod_q;
  logic [32:0]        c_q;
  logic [S_W-1:0]     q_q;
  logic [31:0]        u_q;
  logic [48:0]        plo_q, phi_q;
  logic [S_W-1:0]     t_q;
  logic [55:0]        r_q;

  // Result register.
  logic [IDX_W-1:0]   res_index_q;
  logic [1:0]         res_verdict_q;
  logic               res_add_q;
  logic [16:0]        res_prior_q;

  // Serial units.
  logic                   unit_start;
  logic [LOG_IN_W-1:0]    log_x;
  logic [SQRT_IN_W-1:0]   sqrt_rad;
  logic [DIV_N_W-1:0]     div_n;
  logic [DIV_D_W-1:0]     div_d;
  logic                   log_done, sqrt_done, div_done;
  logic [LOG_W-1:0]       log_res;
  logic [SQRT_ROOT_W-1:0] sqrt_res;
  logic [DIV_N_W-1:0]     div_res;

  // Derived values.
  logic               visited;
  logic               is_b;
  logic               idx_ok;
  logic               child_won;
  logic               child_lost;
  logic [31:0]        base_raw, base_eff, init_sel;
  logic [19:0]        fs_sel;
  logic [LOG_IN_W-1:0] num;
  logic [LOG_W-1:0]   d_log;
  logic [S_W-1:0]     mean, fpu, q_unv;
  logic [64:0]        full;
  logic [S_W-1:0]     r_sat;
  logic [SCORE_W-1:0] sum;
  logic [S_W-1:0]     score;
  logic               new_best;
  verdict_e           verdict;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= 32'd1638400;
      init_q      <= 32'd65536;
      base_root_q <= 32'd1638400;
      init_root_q <= 32'd65536;
      fs_q        <= '0;
      fs_root_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_EXPLORE_BASE:      base_q      <= cfg_wdata_i;
        CFG_EXPLORE_INIT:      init_q      <= cfg_wdata_i;
        CFG_EXPLORE_BASE_ROOT: base_root_q <= cfg_wdata_i;
        CFG_EXPLORE_INIT_ROOT: init_root_q <= cfg_wdata_i;
        CFG_FPU_SCALE:         fs_q        <= cfg_wdata_i[19:0];
        CFG_FPU_SCALE_ROOT:    fs_root_q   <= cfg_wdata_i[19:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted child.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      it_n_q       <= parent_visits_i;
      it_w_q       <= parent_win_sum_i;
      it_ps_q      <= parent_prior_sum_i;
      it_root_q    <= at_root_i;
      it_cw_q      <= child_win_i;
      it_cv_q      <= child_visits_i;
      it_prior_q   <= child_prior_i;
      it_exp_q     <= child_expanded_i;
      it_outcome_q <= child_outcome_i;
      it_first_q   <= first_child_i;
      it_last_q    <= last_child_i;
    end
  end

  // Register selection and the log argument.
  always_comb begin
    base_raw = it_root_q ? base_root_q : base_q;
    base_eff = (base_raw == '0) ? 32'd1 : base_raw;
    init_sel = it_root_q ? init_root_q : init_q;
    fs_sel   = it_root_q ? fs_root_q : fs_q;
    num      = (LOG_IN_W'(it_n_q) << FRAC_BITS) + LOG_IN_W'(base_eff) + LOG_IN_W'(ONE_Q);
    visited  = (it_cv_q != '0);
    idx_ok   = (cnt_q < CNT_W'(MAX_CHILDREN));
    child_won  = it_exp_q && (outcome_e'(it_outcome_q) == OUTCOME_WIN);
    child_lost = it_exp_q && (outcome_e'(it_outcome_q) == OUTCOME_LOSS);
  end

  // Unit operands: pass A does log(num), sqrt(N), the value division;
  // pass B does log(base), sqrt(prior sum), the visit-weight division.
  always_comb begin
    is_b       = (cmd_i.op == OP_START_B);
    unit_start = (cmd_i.op == OP_START_A) || is_b;
    log_x      = is_b ? LOG_IN_W'(base_eff) : num;
    sqrt_rad   = is_b ? (SQRT_IN_W'(it_ps_q) << FRAC_BITS)
                      : (SQRT_IN_W'(it_n_q) << (2 * FRAC_BITS));
    if (is_b) begin
      div_n = DIV_N_W'(ss_q);
      div_d = DIV_D_W'(it_cv_q) + DIV_D_W'(1);
    end else if (visited) begin
      div_n = it_cw_q;
      div_d = DIV_D_W'(it_cv_q);
    end else begin
      div_n = it_w_q;
      div_d = DIV_D_W'(it_n_q);
    end
  end

  puct_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .log_o   (log_res)
  );

  puct_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (unit_start),
    .radicand_i (sqrt_rad),
    .done_o     (sqrt_done),
    .root_o     (sqrt_res)
  );

  puct_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (unit_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quotient_o (div_res)
  );

  // Score arithmetic between the pipeline registers.
  always_comb begin
    d_log = (la_q > lb_q) ? (la_q - lb_q) : '0;
    mean  = (it_n_q == '0) ? SCORE_MAX : sat_score(66'(quot1_q));
    fpu   = S_W'(fpu_prod_q[41:FRAC_BITS]);
    q_unv = '0;
    if (it_w_q != '0 && mean > fpu) begin
      q_unv = mean - fpu;
    end
    full  = 65'(plo_q) + (65'(phi_q) << 16);
    r_sat = sat_score(66'(r_q >> FRAC_BITS));
    sum   = SCORE_W'(q_q) + SCORE_W'(r_sat);
    score = sat_score(66'(sum));
    new_best = ($signed({1'b0, score}) > $signed(best_score_q));
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_CAPTURE_A: begin
        la_q    <= log_res;
        ss_q    <= sqrt_res[31:0];
        quot1_q <= div_res;
      end
      OP_CAPTURE_B: begin
        lb_q    <= log_res;
        sp_q    <= sqrt_res[21:0];
        quot2_q <= div_res[31:0];
      end
      OP_MUL1: begin
        dl_prod_q  <= 52'(d_log) * 52'(LN2_Q30);
        fpu_prod_q <= 42'(fs_sel) * 42'(sp_q);
      end
      OP_MUL2: begin
        c_q <= 33'(dl_prod_q[51:30]) + 33'(init_sel);
        q_q <= visited ? sat_score(66'(quot1_q)) : q_unv;
        if (visited) begin
          u_q <= quot2_q;
        end else begin
          u_q <= (it_n_q == '0) ? ONE_Q : ss_q;
        end
      end
      OP_MUL3: plo_q <= 49'(c_q) * 49'(u_q[15:0]);
      OP_MUL4: phi_q <= 49'(c_q) * 49'(u_q[31:16]);
      OP_MUL5: t_q   <= sat_score(66'(full >> FRAC_BITS));
      OP_MUL6: r_q   <= 56'(t_q) * 56'(it_prior_q);
      default: ;
    endcase
  end

  // Running argmax, proof counters and list framing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q <= SCORE_MIN;
      best_slot_q  <= '0;
      best_exp_q   <= 1'b0;
      best_prior_q <= '0;
      won_q        <= '0;
      lost_q       <= 1'b0;
      cnt_q        <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_FRAME: begin
          if (it_first_q) begin
            best_score_q <= SCORE_MIN;
            best_slot_q  <= '0;
            best_exp_q   <= 1'b0;
            best_prior_q <= '0;
            won_q        <= '0;
            lost_q       <= 1'b0;
            cnt_q        <= '0;
          end
        end
        OP_SCAN: begin
          if (idx_ok) begin
            // The first slot seeds the reported child.
            if (cnt_q == '0) begin
              best_exp_q   <= it_exp_q;
              best_prior_q <= it_prior_q;
            end
            if (child_won) begin
              won_q <= won_q + 1'b1;
              cnt_q <= cnt_q + 1'b1;
            end else if (child_lost) begin
              lost_q <= 1'b1;
            end
          end
        end
        OP_UPDATE: begin
          if (new_best) begin
            best_score_q <= {1'b0, score};
            best_slot_q  <= cnt_q[IDX_W-1:0];
            best_exp_q   <= it_exp_q;
            best_prior_q <= it_prior_q;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        OP_EMIT: begin
          best_score_q <= SCORE_MIN;
          best_slot_q  <= '0;
          best_exp_q   <= 1'b0;
          best_prior_q <= '0;
          won_q        <= '0;
          lost_q       <= 1'b0;
          cnt_q        <= '0;
        end
        default: ;
      endcase
    end
  end

  // Verdict on the parent: every counted child won takes precedence.
  always_comb begin
    verdict = VERDICT_NONE;
    if (cnt_q != '0 && won_q == cnt_q) begin
      verdict = VERDICT_PARENT_LOSS;
    end else if (lost_q) begin
      verdict = VERDICT_PARENT_WIN;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      res_index_q   <= best_slot_q;
      res_verdict_q <= verdict;
      res_add_q     <= best_exp_q;
      res_prior_q   <= best_prior_q;
    end
  end

  assign status_o.idx_ok     = idx_ok;
  assign status_o.child_won  = child_won;
  assign status_o.last       = it_last_q;
  assign status_o.units_done = log_done && sqrt_done && div_done;

  assign best_index_o     = res_index_q;
  assign parent_verdict_o = res_verdict_q;
  assign add_prior_o      = res_add_q;
  assign best_prior_o     = res_prior_q;

  // Won children are a subset of the counted ones.
  a_won_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    won_q <= cnt_q)
    else $error("won child count exceeds list count");

endmodule

@@ hdl/puct_ctrl.sv @@
// ----------------------------------------------------------------------------
// PUCT controller
// Sequences one child at a time through framing, the two serial passes, the
// multiply pipeline and the argmax update, and owns the result beat's valid.
// ----------------------------------------------------------------------------
module puct_ctrl import puct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result slot frees up at the same edge its beat is taken.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_FRAME;
        end
      end
      ST_FRAME: begin
        cmd_o.op = OP_FRAME;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.op = OP_SCAN;
        state_d  = (status_i.idx_ok && !status_i.child_won) ? ST_START_A : ST_FINISH;
      end
      ST_START_A: begin
        cmd_o.op = OP_START_A;
        state_d  = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (status_i.units_done) begin
          cmd_o.op = OP_CAPTURE_A;
          state_d  = ST_START_B;
        end
      end
      ST_START_B: begin
        cmd_o.op = OP_START_B;
        state_d  = ST_WAIT_B;
      end
      ST_WAIT_B: begin
        if (status_i.units_done) begin
          cmd_o.op = OP_CAPTURE_B;
          state_d  = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.op = OP_MUL1;
        state_d  = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.op = OP_MUL2;
        state_d  = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.op = OP_MUL3;
        state_d  = ST_MUL4;
      end
      ST_MUL4: begin
        cmd_o.op = OP_MUL4;
        state_d  = ST_MUL5;
      end
      ST_MUL5: begin
        cmd_o.op = OP_MUL5;
        state_d  = ST_MUL6;
      end
      ST_MUL6: begin
        cmd_o.op = OP_MUL6;
        state_d  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.op = OP_UPDATE;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status_i.last) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (cmd_o.op == OP_EMIT) || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  a_accept_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ST_FRAME)
    else $error("accepted beat did not enter framing");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT) |=> out_valid_q)
    else $error("emitted result not presented");

  a_start_clears_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_START_A) |=> !status_i.units_done)
    else $error("serial units report done right after start");

endmodule

@@ hdl/puct_child_selector.sv @@
// ----------------------------------------------------------------------------
// PUCT child selector
// Scores one node's children with the PUCT rule and reports the best one.
// ----------------------------------------------------------------------------
// Children stream in one beat each and are handled one at a time. A scored
// child's run time is set by two back-to-back passes of the shared bit-serial
// 48-bit divider (the log2 and square-root units run beside it in each pass),
// followed by a six-step multiply pipeline and the argmax update. A proven-win
// child, or one past the 1024th, skips scoring. On the beat marked last the
// result beat is loaded into an output register; the block takes the next
// child while that beat waits, and only holds off emitting a second result
// until the first one has been taken.
module puct_child_selector import puct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [31:0]      parent_visits_i,
  input  logic [47:0]      parent_win_sum_i,
  input  logic [26:0]      parent_prior_sum_i,
  input  logic             at_root_i,
  input  logic [47:0]      child_win_i,
  input  logic [31:0]      child_visits_i,
  input  logic [16:0]      child_prior_i,
  input  logic             child_expanded_i,
  input  logic [1:0]       child_outcome_i,
  input  logic             first_child_i,
  input  logic             last_child_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [IDX_W-1:0] best_index_o,
  output logic [1:0]       parent_verdict_o,
  output logic             add_prior_o,
  output logic [16:0]      best_prior_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  puct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  puct_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .parent_visits_i    (parent_visits_i),
    .parent_win_sum_i   (parent_win_sum_i),
    .parent_prior_sum_i (parent_prior_sum_i),
    .at_root_i          (at_root_i),
    .child_win_i        (child_win_i),
    .child_visits_i     (child_visits_i),
    .child_prior_i      (child_prior_i),
    .child_expanded_i   (child_expanded_i),
    .child_outcome_i    (child_outcome_i),
    .first_child_i      (first_child_i),
    .last_child_i       (last_child_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .best_index_o       (best_index_o),
    .parent_verdict_o   (parent_verdict_o),
    .add_prior_o        (add_prior_o),
    .best_prior_o       (best_prior_o)
  );

endmodule
